// ===== rtl/core/wpp_pkg.sv =====
// Shared types and constants for the WAV stream parser.
package wpp_pkg;

    localparam logic [31:0] TAG_RIFF   = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE   = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT    = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA   = 32'h6174_6164;
    localparam logic [7:0]  PCM_OFFSET = 8'd128;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_END    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_NOT_RIFF = 3'd1,
        ERR_NOT_WAVE = 3'd2,
        ERR_FORMAT   = 3'd3,
        ERR_DEPTH    = 3'd4
    } err_t;

    // One queued result; the back end assembles the sample from the raw bytes.
    typedef struct packed {
        kind_t       kind;
        logic        offset_8bit;
        logic [7:0]  lo_byte;
        logic [7:0]  hi_byte;
        logic [1:0]  channel_count;
        logic [31:0] sample_rate;
        logic [4:0]  source_bits;
        err_t        error_code;
        logic        truncated;
        logic        last;
    } entry_t;

endpackage

// ===== rtl/core/wpp_byte_if.sv =====
// Byte channel carrying the WAV file stream.
interface wpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_file;

    modport source (output valid, output data_byte, output end_of_file, input ready);
    modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== rtl/core/wpp_result_if.sv =====
// Result channel carrying format reports, errors and converted samples.
interface wpp_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [1:0]         channel_count;
    logic [31:0]        sample_rate;
    logic [4:0]         source_bits;
    logic [2:0]         error_code;
    logic               truncated;
    logic               last;

    modport source (
        output valid, output kind, output sample, output channel_count,
        output sample_rate, output source_bits, output error_code,
        output truncated, output last, input ready
    );
    modport sink (
        input valid, input kind, input sample, input channel_count,
        input sample_rate, input source_bits, input error_code,
        input truncated, input last, output ready
    );
endinterface

// ===== rtl/core/wav_pcm_stream_parser_unit.sv =====
// Path: a result is written into the result queue, then loaded into the output register.
// Throughput: one byte per cycle while the result queue is not full.
// A two-entry result queue lets the parser keep taking bytes while the output stalls.
// Reset (rst_n low, asynchronous) returns the parser to the RIFF tag check, clears
// the captured format fields and empties the queue and the output register.
module wav_pcm_stream_parser_unit (
    input  logic         clk,
    input  logic         rst_n,
    wpp_byte_if.sink     byte_ch,
    wpp_result_if.source result_ch
);
    import wpp_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   not_empty;
    entry_t push_entry;
    entry_t head;

    wpp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    wpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    wpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .result_ch  (result_ch)
    );

endmodule

// ===== rtl/core/wpp_front.sv =====
// Front end: accepts bytes, walks the RIFF chunk structure and classifies results.
module wpp_front (
    input  logic            clk,
    input  logic            rst_n,
    wpp_byte_if.sink        byte_ch,
    input  logic            queue_full,
    output logic            push,
    output wpp_pkg::entry_t push_entry
);
    import wpp_pkg::*;

    typedef enum logic [3:0] {
        PH_RIFF = 4'd0,
        PH_RLEN = 4'd1,
        PH_WAVE = 4'd2,
        PH_CHDR = 4'd3,
        PH_FMT  = 4'd4,
        PH_SKIP = 4'd5,
        PH_PAD  = 4'd6,
        PH_DATA = 4'd7,
        PH_DONE = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] count_reg, count_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] length_reg, length_next;
    logic [15:0] format_reg, format_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [7:0]  partial_reg, partial_next;
    logic [1:0]  byte_phase_reg, byte_phase_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] count_inc;
    logic        emit;
    entry_t      ent;

    assign byte_ch.ready = ~queue_full;
    assign accept        = byte_ch.valid & ~queue_full;
    assign b             = byte_ch.data_byte;
    assign count_inc     = count_reg + 32'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        tag_next        = tag_reg;
        length_next     = length_reg;
        format_next     = format_reg;
        channels_next   = channels_reg;
        rate_next       = rate_reg;
        bits_next       = bits_reg;
        partial_next    = partial_reg;
        byte_phase_next = byte_phase_reg;
        emit            = 1'b0;
        ent             = '0;
        ent.kind        = KIND_SAMPLE;
        ent.error_code  = ERR_NONE;

        case (phase_reg)
            PH_RIFF, PH_WAVE:
            begin
                tag_next   = {b, tag_reg[31:8]};
                count_next = count_inc;
                if (count_inc == 32'd4)
                begin
                    count_next = '0;
                    if (phase_reg == PH_RIFF)
                    begin
                        if (tag_next != TAG_RIFF)
                        begin
                            emit           = 1'b1;
                            ent.last       = 1'b1;
                            ent.kind       = KIND_ERROR;
                            ent.error_code = ERR_NOT_RIFF;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_RLEN;
                        end
                    end
                    else
                    begin
                        if (tag_next != TAG_WAVE)
                        begin
                            emit           = 1'b1;
                            ent.last       = 1'b1;
                            ent.kind       = KIND_ERROR;
                            ent.error_code = ERR_NOT_WAVE;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_CHDR;
                        end
                    end
                end
            end
            PH_RLEN:
            begin
                count_next = count_inc;
                if (count_inc == 32'd4)
                begin
                    count_next = '0;
                    phase_next = PH_WAVE;
                end
            end
            PH_CHDR:
            begin
                if (count_reg < 32'd4)
                begin
                    tag_next = {b, tag_reg[31:8]};
                end
                else
                begin
                    length_next = {b, length_reg[31:8]};
                end
                count_next = count_inc;
                if (count_inc == 32'd8)
                begin
                    count_next = '0;
                    if (tag_next == TAG_DATA)
                    begin
                        emit = 1'b1;
                        if (format_reg != 16'd1 || channels_reg > 16'd2)
                        begin
                            ent.kind       = KIND_ERROR;
                            ent.error_code = ERR_FORMAT;
                            ent.last       = 1'b1;
                        end
                        else if (bits_reg != 16'd8 && bits_reg != 16'd16
                                 && bits_reg != 16'd24)
                        begin
                            ent.kind       = KIND_ERROR;
                            ent.error_code = ERR_DEPTH;
                            ent.last       = 1'b1;
                        end
                        else
                        begin
                            ent.kind          = KIND_FORMAT;
                            ent.channel_count = channels_reg[1:0];
                            ent.sample_rate   = rate_reg;
                            ent.source_bits   = bits_reg[4:0];
                            byte_phase_next   = '0;
                            partial_next      = '0;
                            ent.last          = (length_next == 32'd0);
                        end
                        phase_next = ent.last ? PH_DONE : PH_DATA;
                    end
                    else
                    begin
                        phase_next = (tag_next == TAG_FMT) ? PH_FMT : PH_SKIP;
                        // An empty chunk has even length, so no pad byte follows.
                        if (length_next == 32'd0)
                        begin
                            phase_next = PH_CHDR;
                        end
                    end
                end
            end
            PH_FMT, PH_SKIP:
            begin
                if (phase_reg == PH_FMT && count_reg < 32'd18)
                begin
                    case (count_reg[4:0])
                        5'd0:    format_next[7:0]    = b;
                        5'd1:    format_next[15:8]   = b;
                        5'd2:    channels_next[7:0]  = b;
                        5'd3:    channels_next[15:8] = b;
                        5'd4:    rate_next[7:0]      = b;
                        5'd5:    rate_next[15:8]     = b;
                        5'd6:    rate_next[23:16]    = b;
                        5'd7:    rate_next[31:24]    = b;
                        5'd14:   bits_next[7:0]      = b;
                        5'd15:   bits_next[15:8]     = b;
                        default: ;
                    endcase
                end
                count_next = count_inc;
                if (count_inc == length_reg)
                begin
                    phase_next = length_reg[0] ? PH_PAD : PH_CHDR;
                    count_next = '0;
                end
            end
            PH_PAD:
            begin
                phase_next = PH_CHDR;
                count_next = '0;
            end
            PH_DATA:
            begin
                count_next = count_inc;
                if (bits_reg == 16'd8)
                begin
                    emit            = 1'b1;
                    ent.offset_8bit = 1'b1;
                    ent.hi_byte     = b;
                end
                else if (bits_reg == 16'd16)
                begin
                    if (byte_phase_reg == 2'd0)
                    begin
                        partial_next    = b;
                        byte_phase_next = 2'd1;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        ent.lo_byte     = partial_reg;
                        ent.hi_byte     = b;
                        byte_phase_next = 2'd0;
                    end
                end
                else
                begin
                    // A 24-bit sample drops its low byte and keeps the upper two.
                    if (byte_phase_reg == 2'd0)
                    begin
                        byte_phase_next = 2'd1;
                    end
                    else if (byte_phase_reg == 2'd1)
                    begin
                        partial_next    = b;
                        byte_phase_next = 2'd2;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        ent.lo_byte     = partial_reg;
                        ent.hi_byte     = b;
                        byte_phase_next = 2'd0;
                    end
                end
                if (emit)
                begin
                    ent.source_bits = bits_reg[4:0];
                end
                if (count_inc == length_reg)
                begin
                    if (!emit)
                    begin
                        emit     = 1'b1;
                        ent.kind = KIND_END;
                    end
                    ent.last   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
            default: ;
        endcase

        if (byte_ch.end_of_file)
        begin
            if (!ent.last && phase_next != PH_DONE)
            begin
                if (!emit)
                begin
                    emit           = 1'b1;
                    ent.kind       = (phase_next == PH_DATA) ? KIND_END : KIND_ERROR;
                    ent.error_code = ERR_NONE;
                end
                ent.truncated = 1'b1;
                ent.last      = 1'b1;
            end
            phase_next      = PH_RIFF;
            count_next      = '0;
            tag_next        = '0;
            length_next     = '0;
            format_next     = '0;
            channels_next   = '0;
            rate_next       = '0;
            bits_next       = '0;
            partial_next    = '0;
            byte_phase_next = '0;
        end
    end

    assign push       = accept & emit;
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RIFF;
            count_reg      <= '0;
            tag_reg        <= '0;
            length_reg     <= '0;
            format_reg     <= '0;
            channels_reg   <= '0;
            rate_reg       <= '0;
            bits_reg       <= '0;
            partial_reg    <= '0;
            byte_phase_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            tag_reg        <= tag_next;
            length_reg     <= length_next;
            format_reg     <= format_next;
            channels_reg   <= channels_next;
            rate_reg       <= rate_next;
            bits_reg       <= bits_next;
            partial_reg    <= partial_next;
            byte_phase_reg <= byte_phase_next;
        end
    end

endmodule

// ===== rtl/core/wpp_queue.sv =====
// Short result queue between the parser front end and the output back end.
module wpp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  wpp_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output wpp_pkg::entry_t head
);
    import wpp_pkg::*;

    entry_t                   slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;

    localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
    localparam logic [QUEUE_CNT_W-1:0] CNT_ONE  = QUEUE_CNT_W'(1);

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/wpp_back.sv =====
// Back end: builds the PCM sample and holds the result beat in the output register.
module wpp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  wpp_pkg::entry_t head,
    output logic            pop,
    wpp_result_if.source    result_ch
);
    import wpp_pkg::*;

    logic               valid_reg;
    logic [1:0]         kind_reg;
    logic signed [15:0] sample_reg, sample_next;
    logic [1:0]         channels_reg;
    logic [31:0]        rate_reg;
    logic [4:0]         bits_reg;
    logic [2:0]         error_reg;
    logic               truncated_reg;
    logic               last_reg;

    assign pop = head_valid & (~valid_reg | result_ch.ready);

    always_comb
    begin
        sample_next = '0;
        if (head.kind == KIND_SAMPLE)
        begin
            // An 8-bit sample is unsigned; flipping its top bit removes the offset.
            if (head.offset_8bit)
            begin
                sample_next = {head.hi_byte ^ PCM_OFFSET, 8'h00};
            end
            else
            begin
                sample_next = {head.hi_byte, head.lo_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg      <= head.kind;
            sample_reg    <= sample_next;
            channels_reg  <= head.channel_count;
            rate_reg      <= head.sample_rate;
            bits_reg      <= head.source_bits;
            error_reg     <= head.error_code;
            truncated_reg <= head.truncated;
            last_reg      <= head.last;
        end
    end

    assign result_ch.valid         = valid_reg;
    assign result_ch.kind          = kind_reg;
    assign result_ch.sample        = sample_reg;
    assign result_ch.channel_count = channels_reg;
    assign result_ch.sample_rate   = rate_reg;
    assign result_ch.source_bits   = bits_reg;
    assign result_ch.error_code    = error_reg;
    assign result_ch.truncated     = truncated_reg;
    assign result_ch.last          = last_reg;

endmodule
